### rtl/trl_pkg.sv
package trl_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int GROUP_BITS = 10;
   localparam int IDX_BITS   = $clog2(LIST_DEPTH);
   localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
   localparam int ID_BITS    = 64;
   localparam int TAG_BITS   = 10;
   localparam int HOLD_BITS  = 16;
   localparam int ENTRY_BITS = ID_BITS + GROUP_BITS;
   localparam int ADDR_BITS  = 2;

   localparam logic [ADDR_BITS-1:0] REG_HOLD_DELAY = 2'd0;

   typedef enum logic [2:0] {
      OP_FOCUS   = 3'd0,
      OP_CLOSE   = 3'd1,
      OP_MOVE    = 3'd2,
      OP_SWITCH  = 3'd3,
      OP_QGROUP  = 3'd4,
      OP_QPREV   = 3'd5,
      OP_TICK    = 3'd6,
      OP_NONE    = 3'd7
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_POST,
      ST_TAIL_RD,
      ST_TAIL_CHK,
      ST_QRY_RD,
      ST_QRY_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      opcode_type             opcode;
      logic [ID_BITS-1:0]     item_id;
      logic [TAG_BITS-1:0]    group_tag;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]     answer_id;
      logic                   found;
      logic [5:0]             entries_held;
   } rsp_type;

endpackage

### rtl/trl_stream_if.sv
interface trl_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/trl_ram.sv
module trl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/tagged_recency_list.sv
// Channel   Direction  Payload                               Handshake
// req       in         opcode, item_id, group_tag            valid/ready
// rsp       out        answer_id, found, entries_held        valid/ready
// csr       in         hold_delay at address 0 (APB write)   psel/penable, pready=1
//
// One request is worked on at a time. A request that searches or compacts the
// list walks the entry memory, one read and at most one write per cycle: a
// search reads each entry and checks it, and compaction reads and then writes
// each later entry. Reset is synchronous and clears the count, group and timer;
// the entry memory is not cleared since only entries below the count are read.
// A result waits in an output register; req_ready stays low until it is taken.
module tagged_recency_list
   import trl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   trl_stream_if.sink            req,
   trl_stream_if.source          rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Control registers.
   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [GROUP_BITS-1:0]  cur_group_ff, cur_group_in;
   logic [HOLD_BITS-1:0]   hold_ticks_ff, hold_ticks_in;
   logic [HOLD_BITS-1:0]   hold_delay_ff, hold_delay_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Per-request working registers.
   opcode_type             op_ff, op_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [GROUP_BITS-1:0]  grp_ff, grp_in;
   logic [CNT_BITS-1:0]    pos_ff, pos_in;
   logic                   skip_ff, skip_in;
   logic                   hit_ff, hit_in;
   rsp_type                out_ff, out_in;

   // Entry memory: {group, id} per slot.
   logic                   ram_we;
   logic [IDX_BITS-1:0]    ram_waddr, ram_raddr;
   logic [ENTRY_BITS-1:0]  ram_wdata, ram_rdata;
   logic [GROUP_BITS-1:0]  rd_group;
   logic [ID_BITS-1:0]     rd_id;

   trl_ram #(.WIDTH(ENTRY_BITS), .DEPTH(LIST_DEPTH)) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_group = ram_rdata[ENTRY_BITS-1:ID_BITS];
   assign rd_id    = ram_rdata[ID_BITS-1:0];

   // Configuration port: only the hold delay is writable.
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr == REG_HOLD_DELAY) ?
                        {{(32-HOLD_BITS){1'b0}}, hold_delay_ff} : 32'd0;

   always_comb begin
      hold_delay_in = hold_delay_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_HOLD_DELAY) begin
         hold_delay_in = csr_pwdata[HOLD_BITS-1:0];
      end
   end

   assign req.ready     = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.payload   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cur_group_ff  <= '0;
         hold_ticks_ff <= '0;
         hold_delay_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cur_group_ff  <= cur_group_in;
         hold_ticks_ff <= hold_ticks_in;
         hold_delay_ff <= hold_delay_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      id_ff   <= id_in;
      grp_ff  <= grp_in;
      pos_ff  <= pos_in;
      skip_ff <= skip_in;
      hit_ff  <= hit_in;
      out_ff  <= out_in;
   end

   // Sequencer. Removal searches upward for the oldest match, then shifts the
   // later entries down one slot at a time (read, then write). Focus, and a move
   // with no match, go on to ST_POST; the group query walks down from the newest entry.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_group_in  = cur_group_ff;
      hold_ticks_in = hold_ticks_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      grp_in        = grp_ff;
      pos_in        = pos_ff;
      skip_in       = skip_ff;
      hit_in        = hit_ff;
      out_in        = out_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff[IDX_BITS-1:0];
      ram_wdata     = {cur_group_ff, id_ff};
      ram_raddr     = pos_ff[IDX_BITS-1:0];

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               op_in   = req.payload.opcode;
               id_in   = req.payload.item_id;
               grp_in  = req.payload.group_tag[GROUP_BITS-1:0];
               pos_in  = '0;
               hit_in  = 1'b0;
               case (req.payload.opcode)
                  OP_FOCUS, OP_CLOSE, OP_MOVE: state_in = ST_FIND_RD;
                  OP_SWITCH: begin
                     cur_group_in = req.payload.group_tag[GROUP_BITS-1:0];
                     state_in     = ST_DONE;
                  end
                  OP_QGROUP: begin
                     hold_ticks_in = '0;
                     skip_in = (req.payload.group_tag[GROUP_BITS-1:0] == cur_group_ff);
                     pos_in  = count_ff;
                     state_in = ST_QRY_RD;
                  end
                  OP_QPREV: begin
                     hold_ticks_in = '0;
                     if (count_ff >= CNT_BITS'(2)) begin
                        pos_in   = count_ff - CNT_BITS'(2);
                        state_in = ST_TAIL_RD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_TICK: begin
                     if (hold_ticks_ff != '0) begin
                        hold_ticks_in = hold_ticks_ff - HOLD_BITS'(1);
                     end
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FIND_RD: begin
            if (pos_ff >= count_ff) begin
               state_in = ST_POST;
            end else begin
               state_in = ST_FIND_CHK;
            end
         end
         ST_FIND_CHK: begin
            if (rd_id == id_ff) begin
               hit_in = 1'b1;
               if (op_ff == OP_MOVE) begin
                  ram_we   = 1'b1;
                  ram_wdata = {cur_group_ff, rd_id};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end else begin
               pos_in   = pos_ff + CNT_BITS'(1);
               state_in = ST_FIND_RD;
            end
         end
         // Shift entries above pos down by one; pos is the slot being filled.
         ST_SHIFT_RD: begin
            if (pos_ff + CNT_BITS'(1) >= count_ff) begin
               count_in = count_ff - CNT_BITS'(1);
               hit_in   = 1'b0;
               state_in = (op_ff == OP_FOCUS) ? ST_POST : ST_DONE;
            end else begin
               ram_raddr = IDX_BITS'(pos_ff + CNT_BITS'(1));
               state_in  = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            pos_in    = pos_ff + CNT_BITS'(1);
            state_in  = ST_SHIFT_RD;
         end
         ST_POST: begin
            if (op_ff == OP_CLOSE) begin
               state_in = ST_DONE;
            end else if (op_ff == OP_FOCUS && hold_ticks_ff != '0 && count_ff != '0) begin
               pos_in   = count_ff - CNT_BITS'(1);
               state_in = ST_TAIL_RD;
            end else if (count_ff == CNT_BITS'(LIST_DEPTH)) begin
               // Full: drop the oldest entry, then append in the last slot.
               pos_in   = '0;
               hit_in   = 1'b0;
               state_in = ST_SHIFT_RD;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = IDX_BITS'(count_ff);
               count_in  = count_ff + CNT_BITS'(1);
               if (op_ff == OP_FOCUS) begin
                  hold_ticks_in = hold_delay_ff;
               end
               state_in  = ST_DONE;
            end
         end
         ST_TAIL_RD: state_in = ST_TAIL_CHK;
         ST_TAIL_CHK: begin
            if (op_ff == OP_QPREV) begin
               out_in.answer_id = rd_id;
               out_in.found     = 1'b1;
               hit_in           = 1'b1;
               state_in         = ST_DONE;
            end else if (rd_group == cur_group_ff) begin
               ram_we        = 1'b1;
               hold_ticks_in = hold_delay_ff;
               state_in      = ST_DONE;
            end else if (count_ff == CNT_BITS'(LIST_DEPTH)) begin
               pos_in   = '0;
               skip_in  = 1'b0;
               state_in = ST_SHIFT_RD;
            end else begin
               ram_we        = 1'b1;
               ram_waddr     = IDX_BITS'(count_ff);
               count_in      = count_ff + CNT_BITS'(1);
               hold_ticks_in = hold_delay_ff;
               state_in      = ST_DONE;
            end
         end
         ST_QRY_RD: begin
            if (pos_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               ram_raddr = IDX_BITS'(pos_ff - CNT_BITS'(1));
               state_in  = ST_QRY_CHK;
            end
         end
         ST_QRY_CHK: begin
            pos_in   = pos_ff - CNT_BITS'(1);
            state_in = ST_QRY_RD;
            if (rd_group == grp_ff) begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else begin
                  out_in.answer_id = rd_id;
                  out_in.found     = 1'b1;
                  hit_in           = 1'b1;
                  state_in         = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!((op_ff == OP_QGROUP || op_ff == OP_QPREV) && hit_ff)) begin
               out_in.answer_id = '0;
               out_in.found     = 1'b0;
            end
            out_in.entries_held = 6'(count_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // A shift without a removed match drops the oldest entry of a full list;
      // once it reaches the top, the new entry goes into the last slot. Only a
      // focus reloads the hold timer.
      if (state_ff == ST_SHIFT_RD && !hit_ff && pos_ff + CNT_BITS'(1) >= count_ff &&
          count_ff == CNT_BITS'(LIST_DEPTH)) begin
         state_in  = ST_DONE;
         ram_we    = 1'b1;
         ram_waddr = IDX_BITS'(count_ff - CNT_BITS'(1));
         ram_wdata = {cur_group_ff, id_ff};
         count_in  = count_ff;
         if (op_ff == OP_FOCUS) begin
            hold_ticks_in = hold_delay_ff;
         end
      end
   end

endmodule

### rtl/trl_checker.sv
module trl_checker
   import trl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_type rsp_payload
);
   always @(posedge clock) begin
      assert property (disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
         else $error("result changed while stalled");
      assert property (disable iff (reset)
         rsp_valid |-> rsp_payload.entries_held <= 6'(LIST_DEPTH))
         else $error("entry count out of range");
      assert property (disable iff (reset)
         rsp_valid && !rsp_payload.found |-> rsp_payload.answer_id == '0)
         else $error("answer without a find");
      assert property (disable iff (reset)
         req_valid && req_ready |=> !req_ready)
         else $error("second request taken while busy");
   end
endmodule

bind tagged_recency_list trl_checker u_trl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

### bench/testbench.sv
module testbench;
   import trl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   trl_stream_if #(.payload_type(req_type)) req_ch ();
   trl_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr   = '0;
   logic [31:0]          csr_pwdata  = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   tagged_recency_list uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
   end

   // Shadow copy of the recency list, kept oldest to newest.
   logic [ID_BITS-1:0]   shadow_id [LIST_DEPTH];
   logic [TAG_BITS-1:0]  shadow_tag [LIST_DEPTH];
   int unsigned          shadow_len;
   logic [TAG_BITS-1:0]  shadow_group;
   logic [HOLD_BITS-1:0] shadow_hold;
   logic [HOLD_BITS-1:0] shadow_hold_reload;

   // Answers still owed by the block, oldest first.
   rsp_type pending_answers[$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned mismatch_count;
   int unsigned unexpected_count;
   int unsigned answers_checked;
   int unsigned items_sent;
   int unsigned hits_seen;
   int unsigned cycle_count;

   function automatic void shadow_drop_at(int unsigned pos);
      for (int unsigned k = pos; k + 1 < shadow_len; k++) begin
         shadow_id[k]  = shadow_id[k + 1];
         shadow_tag[k] = shadow_tag[k + 1];
      end
      shadow_len--;
   endfunction

   // Only the oldest entry carrying the id is taken out.
   function automatic void shadow_remove(logic [ID_BITS-1:0] id);
      for (int unsigned k = 0; k < shadow_len; k++) begin
         if (shadow_id[k] == id) begin
            shadow_drop_at(k);
            return;
         end
      end
   endfunction

   function automatic void shadow_append(logic [TAG_BITS-1:0] tag, logic [ID_BITS-1:0] id);
      if (shadow_len >= LIST_DEPTH) shadow_drop_at(0);
      shadow_tag[shadow_len] = tag;
      shadow_id[shadow_len]  = id;
      shadow_len++;
   endfunction

   // Applies one request to the shadow list and returns the answer it owes.
   function automatic rsp_type recency_predict(req_type r);
      rsp_type      ans;
      bit           skip_newest;
      int unsigned  k;
      ans = '0;
      case (r.opcode)
         OP_FOCUS: begin
            shadow_remove(r.item_id);
            if (shadow_hold != 0 && shadow_len != 0 &&
                shadow_tag[shadow_len - 1] == shadow_group) begin
               shadow_id[shadow_len - 1] = r.item_id;
            end else begin
               shadow_append(shadow_group, r.item_id);
            end
            shadow_hold = shadow_hold_reload;
         end
         OP_CLOSE: shadow_remove(r.item_id);
         OP_MOVE: begin
            for (k = 0; k < shadow_len; k++) begin
               if (shadow_id[k] == r.item_id) break;
            end
            if (k < shadow_len) shadow_tag[k] = shadow_group;
            else shadow_append(shadow_group, r.item_id);
         end
         OP_SWITCH: shadow_group = r.group_tag;
         OP_QGROUP: begin
            skip_newest = (r.group_tag == shadow_group);
            shadow_hold = 0;
            for (k = shadow_len; k > 0; k--) begin
               if (shadow_tag[k - 1] == r.group_tag) begin
                  if (skip_newest) begin
                     skip_newest = 1'b0;
                  end else begin
                     ans.answer_id = shadow_id[k - 1];
                     ans.found     = 1'b1;
                     break;
                  end
               end
            end
         end
         OP_QPREV: begin
            shadow_hold = 0;
            if (shadow_len >= 2) begin
               ans.answer_id = shadow_id[shadow_len - 2];
               ans.found     = 1'b1;
            end
         end
         OP_TICK: begin
            if (shadow_hold != 0) shadow_hold--;
         end
         default: ;
      endcase
      ans.entries_held = 6'(shadow_len);
      return ans;
   endfunction

   // Offers one request, sometimes after a random gap, and records its answer on transfer.
   task automatic send_item(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      pending_answers.push_back(recency_predict(r));
      items_sent++;
   endtask

   task automatic send_op(opcode_type op, logic [ID_BITS-1:0] id, logic [TAG_BITS-1:0] tag);
      req_type r;
      r.opcode    = op;
      r.item_id   = id;
      r.group_tag = tag;
      send_item(r);
   endtask

   // The register is only written once every answer has come back.
   task automatic write_hold_delay(logic [HOLD_BITS-1:0] value);
      @(posedge clock);
      req_ch.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_HOLD_DELAY;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      shadow_hold_reload = value;
   endtask

   // Checks each result transfer against the oldest owed answer and draws the
   // next ready value.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
               $display("ERROR: result with no request waiting: %h", rsp_ch.payload);
         end else begin
            want = pending_answers.pop_front();
            answers_checked++;
            if (want.found) hits_seen++;
            if (rsp_ch.payload.answer_id !== want.answer_id ||
                rsp_ch.payload.found !== want.found ||
                rsp_ch.payload.entries_held !== want.entries_held) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= 10)
                  $display("ERROR: id %h found %b held %0d, expected id %h found %b held %0d",
                           rsp_ch.payload.answer_id, rsp_ch.payload.found,
                           rsp_ch.payload.entries_held, want.answer_id, want.found,
                           want.entries_held);
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Empty list: both queries miss, a tick at zero stays at zero, the no-op
   // opcode leaves everything alone, and a focus on the empty list appends.
   task automatic test_empty_list_cases();
      send_op(OP_QPREV, '0, '0);
      send_op(OP_QGROUP, '0, '0);
      send_op(OP_TICK, '0, '0);
      send_op(OP_NONE, '1, '1);
      send_op(OP_CLOSE, 64'd5, '0);
      send_op(OP_FOCUS, 64'd7, '0);
      send_op(OP_QPREV, '0, '0);
      send_op(OP_CLOSE, 64'd7, '0);
   endtask

   // Extreme ids and tags, a move that retags and one that appends, and a
   // group query that skips the newest entry of the current group.
   task automatic test_field_extremes();
      send_op(OP_SWITCH, '0, '1);
      send_op(OP_FOCUS, '1, '0);
      send_op(OP_FOCUS, '0, '0);
      send_op(OP_MOVE, 64'h8000_0000_0000_0001, '0);
      send_op(OP_SWITCH, '0, 10'd0);
      send_op(OP_MOVE, '1, '0);
      send_op(OP_QGROUP, '0, '1);
      send_op(OP_QGROUP, '0, 10'd0);
      send_op(OP_QPREV, '0, '0);
      send_op(OP_NONE, '0, '0);
   endtask

   // Fill beyond the depth so the oldest entries fall off.
   task automatic test_full_list();
      for (int i = 0; i < LIST_DEPTH + 3; i++)
         send_op(OP_FOCUS, 64'(100 + i), 10'(i % 3));
      send_op(OP_QPREV, '0, '0);
      send_op(OP_CLOSE, 64'd100, '0);
      send_op(OP_CLOSE, 64'd110, '0);
   endtask

   // With the timer running a focus overwrites the newest entry; ticks and
   // queries stop that.
   task automatic test_hold_timer();
      write_hold_delay(16'd3);
      send_op(OP_SWITCH, '0, 10'd5);
      send_op(OP_FOCUS, 64'd200, '0);
      send_op(OP_FOCUS, 64'd201, '0);
      repeat (4) send_op(OP_TICK, '0, '0);
      send_op(OP_FOCUS, 64'd202, '0);
      send_op(OP_QGROUP, '0, 10'd5);
      send_op(OP_FOCUS, 64'd203, '0);
      send_op(OP_TICK, '0, '0);
      send_op(OP_FOCUS, 64'd204, '0);
      send_op(OP_QPREV, '0, '0);
   endtask

   function automatic logic [ID_BITS-1:0] pick_id();
      case ($urandom_range(19))
         0:       return {$urandom, $urandom};
         1:       return '1;
         default: return 64'($urandom_range(47));
      endcase
   endfunction

   function automatic logic [TAG_BITS-1:0] pick_tag();
      if ($urandom_range(9) == 0) return 10'($urandom);
      return 10'($urandom_range(3));
   endfunction

   // Focus is the most common opcode, over a small pool of ids and groups, so the
   // list fills, overwrites and compacts; the rest is every other opcode.
   task automatic test_random_traffic(int unsigned count);
      req_type     r;
      int unsigned w;
      for (int unsigned n = 0; n < count; n++) begin
         w = $urandom_range(99);
         if (w < 32)      r.opcode = OP_FOCUS;
         else if (w < 42) r.opcode = OP_CLOSE;
         else if (w < 52) r.opcode = OP_MOVE;
         else if (w < 60) r.opcode = OP_SWITCH;
         else if (w < 74) r.opcode = OP_QGROUP;
         else if (w < 84) r.opcode = OP_QPREV;
         else if (w < 97) r.opcode = OP_TICK;
         else             r.opcode = OP_NONE;
         r.item_id   = pick_id();
         r.group_tag = pick_tag();
         send_item(r);
      end
   endtask

   initial begin
      shadow_len         = 0;
      shadow_group       = '0;
      shadow_hold        = '0;
      shadow_hold_reload = '0;
      send_idle_pct      = 33;
      recv_idle_pct      = 76;
      mismatch_count     = 0;
      unexpected_count   = 0;
      answers_checked    = 0;
      items_sent         = 0;
      hits_seen          = 0;
      cycle_count        = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The hold delay starts at its reset value of zero.
      test_empty_list_cases();
      test_field_extremes();
      test_full_list();
      test_hold_timer();

      write_hold_delay(16'hFFFF);
      test_random_traffic(630);

      send_idle_pct = 76;
      recv_idle_pct = 33;
      write_hold_delay(16'd2);
      test_random_traffic(630);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_hold_delay(16'($urandom_range(1, 8)));
      test_random_traffic(320);
      write_hold_delay(16'd0);
      test_random_traffic(320);

      @(posedge clock);
      req_ch.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests across five hold settings; %0d results checked, %0d hits.",
               items_sent, answers_checked, hits_seen);
      $display("Mismatches: %0d, unexpected results: %0d.", mismatch_count, unexpected_count);
      if (mismatch_count == 0 && unexpected_count == 0 && pending_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
